>>> hw/rtl/hbw_pkg.sv
// ----------------------------------------------------------------------------
// hbw_pkg
// shared constants and types of the node heartbeat watchdog
// ----------------------------------------------------------------------------
package hbw_pkg;

    localparam int NODE_COUNT_DEF = 64;
    localparam int ADDR_W_MAX     = 8;
    localparam int NODE_W         = 8;
    localparam int TIME_W         = 32;
    localparam int OWN_ID_W       = 16;
    localparam int STOP_W         = 8;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 1'b1;

    localparam logic [OWN_ID_W-1:0] OWN_NODE_ID_RST = 16'd252;
    localparam logic [TIME_W-1:0]   TIMEOUT_MS_RST  = 32'd500;
    localparam logic [STOP_W-1:0]   STOP_CODE       = 8'h02;

    localparam logic CMD_HEARTBEAT = 1'b0;
    localparam logic CMD_SCAN      = 1'b1;

    typedef struct packed {
        logic                  en;
        logic [ADDR_W_MAX-1:0] addr;
    } tbl_rd_t;

    typedef struct packed {
        logic                  en;
        logic [ADDR_W_MAX-1:0] addr;
        logic [TIME_W-1:0]     data;
    } tbl_wr_t;

endpackage

>>> hw/rtl/hbw_ram.sv
// ----------------------------------------------------------------------------
// hbw_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module hbw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/hbw_table.sv
// ----------------------------------------------------------------------------
// hbw_table
// last-seen time table: ram plus per-node valid bits, unwritten nodes read 0
// ----------------------------------------------------------------------------
module hbw_table #(
    parameter int NODE_COUNT = hbw_pkg::NODE_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hbw_pkg::tbl_wr_t            wr,
    input  hbw_pkg::tbl_rd_t            rd,
    output logic [hbw_pkg::TIME_W-1:0]  seen
);

    localparam int AW = $clog2(NODE_COUNT);

    logic [NODE_COUNT-1:0]        valid_reg;
    logic                         rd_valid_reg;
    logic [hbw_pkg::TIME_W-1:0]   rd_data;

    hbw_ram #(
        .WIDTH (hbw_pkg::TIME_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr[AW-1:0]),
        .wr_data (wr.data),
        .rd_en   (rd.en),
        .rd_addr (rd.addr[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
            if (rd.en) begin
                rd_valid_reg <= valid_reg[rd.addr[AW-1:0]];
            end
        end
    end

    assign seen = rd_valid_reg ? rd_data : '0;

endmodule

>>> hw/rtl/hbw_scan.sv
// ----------------------------------------------------------------------------
// hbw_scan
// scan engine: walks the table, checks timeouts, holds one alarm back so the
// final one can be flagged, and drives the alarm output register
// ----------------------------------------------------------------------------
module hbw_scan #(
    parameter int NODE_COUNT = hbw_pkg::NODE_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [hbw_pkg::TIME_W-1:0]    now_ms,
    input  logic [hbw_pkg::TIME_W-1:0]    timeout_ms,
    output logic                          busy,
    output hbw_pkg::tbl_rd_t              rd,
    input  logic [hbw_pkg::TIME_W-1:0]    seen,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hbw_pkg::NODE_W-1:0]    dead_node,
    output logic                          out_last
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int CW = AW + 1;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t                      state_reg,    state_next;
    logic [CW-1:0]               rd_addr_reg,  rd_addr_next;
    logic [hbw_pkg::TIME_W-1:0]  now_reg,      now_next;
    logic                        cmp_vld_reg,  cmp_vld_next;
    logic [AW-1:0]               cmp_idx_reg,  cmp_idx_next;
    logic                        pend_vld_reg, pend_vld_next;
    logic [AW-1:0]               pend_idx_reg, pend_idx_next;
    logic                        out_vld_reg,  out_vld_next;
    logic [AW-1:0]               out_idx_reg,  out_idx_next;
    logic                        out_last_reg, out_last_next;

    logic                        out_free;
    logic                        hit;
    logic                        cmp_go;
    logic                        issue_more;
    logic                        rd_en;
    logic                        out_push;
    logic                        push_last;
    logic [hbw_pkg::TIME_W:0]    deadline;

    always_comb begin
        state_next    = state_reg;
        rd_addr_next  = rd_addr_reg;
        now_next      = now_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        out_vld_next  = out_vld_reg;
        out_idx_next  = out_idx_reg;
        out_last_next = out_last_reg;
        rd_en         = 1'b0;
        out_push      = 1'b0;
        push_last     = 1'b0;

        out_free   = !out_vld_reg || out_ready;
        deadline   = {1'b0, seen} + {1'b0, timeout_ms};
        hit        = cmp_vld_reg && (seen != '0) && ({1'b0, now_reg} > deadline);
        cmp_go     = !cmp_vld_reg || !hit || !pend_vld_reg || out_free;
        issue_more = rd_addr_reg < CW'(NODE_COUNT);

        if (out_ready) begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next   = ST_WALK;
                    rd_addr_next = CW'(1);
                    now_next     = now_ms;
                end
            end
            ST_WALK: begin
                if (hit) begin
                    if (!pend_vld_reg) begin
                        pend_vld_next = 1'b1;
                        pend_idx_next = cmp_idx_reg;
                    end else if (out_free) begin
                        out_push      = 1'b1;
                        pend_idx_next = cmp_idx_reg;
                    end
                end
                if (cmp_go) begin
                    cmp_vld_next = 1'b0;
                    if (issue_more) begin
                        rd_en        = 1'b1;
                        cmp_vld_next = 1'b1;
                        cmp_idx_next = rd_addr_reg[AW-1:0];
                        rd_addr_next = rd_addr_reg + CW'(1);
                    end
                end
                // walk finished: flush the held alarm as the final one
                if (!cmp_vld_reg && !issue_more) begin
                    if (!pend_vld_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        out_push      = 1'b1;
                        push_last     = 1'b1;
                        pend_vld_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_push) begin
            out_vld_next  = 1'b1;
            out_idx_next  = pend_idx_reg;
            out_last_next = push_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cmp_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            rd_addr_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            cmp_vld_reg  <= cmp_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            rd_addr_reg  <= rd_addr_next;
        end
        now_reg      <= now_next;
        cmp_idx_reg  <= cmp_idx_next;
        pend_idx_reg <= pend_idx_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rd.en     = rd_en;
    assign rd.addr   = hbw_pkg::ADDR_W_MAX'(rd_addr_reg[AW-1:0]);
    assign out_valid = out_vld_reg;
    assign dead_node = hbw_pkg::NODE_W'(out_idx_reg);
    assign out_last  = out_last_reg;

    a_pend_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_vld_reg |-> (state_reg == ST_WALK))
        else $error("held alarm outside a scan");

    a_cmp_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (state_reg == ST_WALK))
        else $error("compare stage busy outside a scan");

    a_no_node_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (cmp_idx_reg != '0))
        else $error("node zero scanned");

    a_last_ends_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_push && push_last) |=> (state_reg == ST_IDLE))
        else $error("final alarm sent but scan still running");

endmodule

>>> hw/rtl/node_heartbeat_watchdog_unit.sv
// ----------------------------------------------------------------------------
// node_heartbeat_watchdog_unit
// heartbeat time table per node with timeout scan raising emergency-stop alarms
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/tready    tuser: command; tdata: node_id, now_ms
//  m_       out  m_tvalid/tready    tdata: dead_node, frame_id, stop_code; tlast
//  cfg_     in   cfg_valid/ready    cfg_index, cfg_data
//
//  heartbeat: a single ram write per request; out-of-range ids write nothing
//  scan: walks nodes 1 to NODE_COUNT-1, one table read per cycle unless m_ stalls
//  s_tready is low for the whole scan; an alarm waits in the output register
//  aresetn clears the per-node valid bits, so the table reads zero at once
// ----------------------------------------------------------------------------
module node_heartbeat_watchdog_unit #(
    parameter int NODE_COUNT = hbw_pkg::NODE_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hbw_pkg::S_TDATA_W-1:0]    s_tdata,   // node_id, now_ms
    input  logic                             s_tuser,   // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hbw_pkg::M_TDATA_W-1:0]    m_tdata,   // dead_node, frame_id, stop_code
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hbw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [hbw_pkg::OWN_ID_W-1:0] own_node_id_reg;
    logic [hbw_pkg::TIME_W-1:0]   timeout_ms_reg;

    logic [hbw_pkg::NODE_W-1:0]   s_node_id;
    logic [hbw_pkg::TIME_W-1:0]   s_now_ms;
    logic                         s_accept;
    logic                         scan_busy;
    logic                         in_range;
    hbw_pkg::tbl_wr_t             tbl_wr;
    hbw_pkg::tbl_rd_t             tbl_rd;
    logic [hbw_pkg::TIME_W-1:0]   tbl_seen;
    logic [hbw_pkg::NODE_W-1:0]   dead_node;

    assign s_node_id = s_tdata[7:0];
    assign s_now_ms  = s_tdata[39:8];
    assign s_tready  = !scan_busy;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ids at or above the table size are dropped
    assign in_range    = {1'b0, s_node_id} < 9'(NODE_COUNT);
    assign tbl_wr.en   = s_accept && (s_tuser == hbw_pkg::CMD_HEARTBEAT) && in_range;
    assign tbl_wr.addr = s_node_id;
    assign tbl_wr.data = s_now_ms;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_node_id_reg <= hbw_pkg::OWN_NODE_ID_RST;
            timeout_ms_reg  <= hbw_pkg::TIMEOUT_MS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hbw_pkg::REG_OWN_NODE_ID: own_node_id_reg <= cfg_data[15:0];
                hbw_pkg::REG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    hbw_table #(
        .NODE_COUNT (NODE_COUNT)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .seen    (tbl_seen)
    );

    hbw_scan #(
        .NODE_COUNT (NODE_COUNT)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_accept && (s_tuser == hbw_pkg::CMD_SCAN)),
        .now_ms     (s_now_ms),
        .timeout_ms (timeout_ms_reg),
        .busy       (scan_busy),
        .rd         (tbl_rd),
        .seen       (tbl_seen),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .dead_node  (dead_node),
        .out_last   (m_tlast)
    );

    assign m_tdata = {hbw_pkg::STOP_CODE, own_node_id_reg, dead_node};

endmodule

>>> sim/hbw_alarm_checker.sv
// ----------------------------------------------------------------------------
// hbw_alarm_checker
// watches the request, alarm and register channels of the heartbeat watchdog,
// keeps its own copy of the heartbeat table and registers, works out the
// alarms each scan request should raise and compares every alarm that leaves
// the block against the oldest one still due
// ----------------------------------------------------------------------------
module hbw_alarm_checker #(
    parameter int NODE_COUNT = hbw_pkg::NODE_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [hbw_pkg::S_TDATA_W-1:0]    s_tdata,   // node_id, now_ms
    input  logic                             s_tuser,   // command
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [hbw_pkg::M_TDATA_W-1:0]    m_tdata,   // dead_node, frame_id, stop_code
    input  logic                             m_tlast,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [hbw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbw_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               fail_count,
    output int                               pending
);
    import hbw_pkg::*;

    typedef struct packed {
        logic [NODE_W-1:0]   dead_node;
        logic [OWN_ID_W-1:0] frame_id;
        logic [STOP_W-1:0]   stop_code;
        logic                last;
    } alarm_t;

    logic [TIME_W-1:0]   heard_ms [NODE_COUNT];
    logic [OWN_ID_W-1:0] own_id;
    logic [TIME_W-1:0]   silence_ms;
    alarm_t              alarm_due [$];
    alarm_t              got;
    alarm_t              want;
    int                  errs;
    int                  waiting;

    assign fail_count = errs;
    assign pending    = waiting;

    function automatic bit node_dead(input int k, input logic [TIME_W-1:0] now);
        // limit formed at 33 bits so a late heartbeat never wraps into an alarm
        return (heard_ms[k] != '0) &&
               ({1'b0, now} > ({1'b0, heard_ms[k]} + {1'b0, silence_ms}));
    endfunction

    task automatic predict_scan_alarms(input logic [TIME_W-1:0] now);
        int     final_k;
        alarm_t a;
        final_k = 0;
        for (int k = 1; k < NODE_COUNT; k++) begin
            if (node_dead(k, now)) final_k = k;
        end
        for (int k = 1; k < NODE_COUNT; k++) begin
            if (node_dead(k, now)) begin
                a.dead_node = k[NODE_W-1:0];
                a.frame_id  = own_id;
                a.stop_code = STOP_CODE;
                a.last      = (k == final_k);
                alarm_due.push_back(a);
            end
        end
    endtask

    task automatic note_fail(input string what, input alarm_t exp_a, input alarm_t act_a);
        if (errs < 10) begin
            $display("%0t hbw_alarm_checker: %s: expected node %0d id %h code %h last %b,",
                     $realtime, what, exp_a.dead_node, exp_a.frame_id, exp_a.stop_code,
                     exp_a.last);
            $display("    got node %0d id %h code %h last %b",
                     act_a.dead_node, act_a.frame_id, act_a.stop_code, act_a.last);
        end
        errs++;
    endtask

    initial begin
        errs    = 0;
        waiting = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NODE_COUNT; k++) heard_ms[k] = '0;
            own_id     = OWN_NODE_ID_RST;
            silence_ms = TIMEOUT_MS_RST;
            alarm_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.dead_node = m_tdata[7:0];
                got.frame_id  = m_tdata[23:8];
                got.stop_code = m_tdata[31:24];
                got.last      = m_tlast;
                if (alarm_due.size() == 0) begin
                    want = '0;
                    note_fail("alarm with none due", want, got);
                end else begin
                    want = alarm_due.pop_front();
                    if (got.dead_node !== want.dead_node || got.frame_id !== want.frame_id ||
                        got.stop_code !== want.stop_code || got.last !== want.last) begin
                        note_fail("alarm mismatch", want, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OWN_NODE_ID: own_id = cfg_data[OWN_ID_W-1:0];
                    REG_TIMEOUT_MS:  silence_ms = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_SCAN) begin
                    predict_scan_alarms(s_tdata[39:8]);
                end else if (s_tdata[7:0] < NODE_COUNT) begin
                    heard_ms[s_tdata[7:0]] = s_tdata[39:8];
                end
            end
        end
        waiting = alarm_due.size();
    end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// heartbeat watchdog testbench: a directed pass over the edge cases of the
// timeout scan, then random heartbeat and scan traffic under several register
// settings and handshake idling patterns, with one long stall on the alarm side
// ----------------------------------------------------------------------------
module tb_top;
    import hbw_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // node_id, now_ms
    logic                  s_tuser;   // command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // dead_node, frame_id, stop_code
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    fail_count;
    int                    pending;
    int                    tx_idle_pct = 6;
    int                    rx_idle_pct = 68;
    bit                    hold_go     = 1'b0;
    bit                    hold_done   = 1'b0;
    logic [TIME_W-1:0]     clk_ms;
    logic [TIME_W-1:0]     tmo;

    node_heartbeat_watchdog_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hbw_alarm_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(8 * 2_000_000);
        $display("tb_top: done, errors");
        $finish;
    end

    // alarm side, with one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                for (int n = 0; n < 400; n++) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic offer_request(input logic cmd, input logic [NODE_W-1:0] node,
                                 input logic [TIME_W-1:0] now);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {now, node};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic beat(input logic [NODE_W-1:0] node, input logic [TIME_W-1:0] now);
        offer_request(CMD_HEARTBEAT, node, now);
    endtask

    task automatic scan(input logic [TIME_W-1:0] now);
        offer_request(CMD_SCAN, NODE_W'($urandom_range(0, 255)), now);
    endtask

    // lets every due alarm out, then the rest of a table walk
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (3 * NODE_COUNT_DEF) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            scan(($urandom_range(0, 19) == 0) ? $urandom : clk_ms);
        end else if (r < 18) begin
            offer_request(1'($urandom_range(0, 1)), NODE_W'($urandom_range(0, 255)), $urandom);
        end else if (r < 24) begin
            beat(NODE_W'($urandom_range(NODE_COUNT_DEF, 255)), clk_ms);
        end else if (r < 27) begin
            beat(NODE_W'($urandom_range(0, NODE_COUNT_DEF - 1)), '0);
        end else begin
            beat(NODE_W'($urandom_range(0, NODE_COUNT_DEF - 1)), clk_ms);
        end
        clk_ms = clk_ms + $urandom_range(0, 40);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = CMD_HEARTBEAT;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_OWN_NODE_ID;
        cfg_data  = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset register values, empty table first
        scan(32'd1000);
        beat(8'd1, 32'd100);
        beat(8'd63, 32'hFFFF_FF00);
        beat(8'd0, 32'd5);
        beat(8'd64, 32'd7);
        beat(8'd255, 32'd9);
        beat(8'd2, 32'd0);
        beat(8'd3, 32'd1000);
        scan(32'd601);
        scan(32'd600);
        scan(32'hFFFF_FFFF);
        beat(8'd1, 32'd0);
        scan(32'hFFFF_FFFF);
        scan(32'd0);
        drain();

        write_reg(REG_OWN_NODE_ID, 32'hFFFF_FFFF);
        write_reg(REG_TIMEOUT_MS, 32'd0);
        scan(32'd1001);
        beat(8'd1, 32'd1);
        scan(32'd2);
        drain();

        write_reg(REG_TIMEOUT_MS, 32'hFFFF_FFFF);
        write_reg(REG_OWN_NODE_ID, 32'd0);
        scan(32'hFFFF_FFFF);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 68;
                end
                1: begin
                    tx_idle_pct = 68;
                    rx_idle_pct = 6;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int sub = 0; sub < 4; sub++) begin
                drain();
                write_reg(REG_OWN_NODE_ID, $urandom);
                case (sub)
                    0: tmo = $urandom_range(1, 300);
                    1: tmo = '0;
                    2: tmo = $urandom;
                    default: tmo = (mode == 0) ? 32'hFFFF_FFFF : $urandom_range(50, 800);
                endcase
                write_reg(REG_TIMEOUT_MS, tmo);
                clk_ms = (sub == 2) ? $urandom : $urandom_range(1, 5000);
                if (mode == 0 && sub == 0) begin
                    // several dead nodes while the alarm side holds off
                    hold_go = 1'b1;
                    beat(8'd5, 32'd1);
                    beat(8'd6, 32'd1);
                    scan(32'hFFFF_FFFF);
                end
                repeat (30) random_request();
            end
        end
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/hbw_pkg.sv
hw/rtl/hbw_ram.sv
hw/rtl/hbw_table.sv
hw/rtl/hbw_scan.sv
hw/rtl/node_heartbeat_watchdog_unit.sv
sim/hbw_alarm_checker.sv
sim/tb_top.sv
